// ===== rtl/incremental_cycle_check_macros.svh =====
// Assertion macros shared by the incremental cycle check RTL.
`ifndef INCREMENTAL_CYCLE_CHECK_MACROS_SVH
`define INCREMENTAL_CYCLE_CHECK_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ICC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ICC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

// ===== rtl/icc_pkg.sv =====
// Shared constants and controller/datapath interface types for the cycle check.
`default_nettype none
package icc_pkg;

	localparam int MAX_NODES  = 32;
	localparam int NODE_W     = $clog2(MAX_NODES);
	localparam int CNT_W      = $clog2(MAX_NODES) + 1;
	localparam int DEG_W      = 6;
	localparam int REL_W      = 16;
	localparam int PADDR_W    = 3;

	localparam logic [DEG_W-1:0]  DEG_MAX          = '1;
	localparam logic [REL_W-1:0]  REL_MAX          = '1;
	localparam logic [5:0]        NODE_COUNT_RESET = 6'd26;
	localparam logic [CNT_W-1:0]  MAX_NODES_CNT    = CNT_W'(MAX_NODES);

	// Register index of node_count
	localparam logic [0:0] REG_NODE_COUNT = 1'b0;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic load;        // capture item, advance relation counter
		logic rd_src;      // read adjacency row of the source node
		logic wr_edge;     // merge the edge into the graph
		logic peel_init;   // copy in-degrees, seed ready set
		logic peel_pick;   // take the lowest ready node, read its row
		logic peel_apply;  // decrement successors of the taken node
		logic finish;      // update flag, load output register
	} icc_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic in_range;    // captured item names nodes below the limit
		logic ready_any;   // ready set is not empty
		logic cycle_flag;  // sticky inconsistency flag
	} icc_sts_t;

endpackage
`default_nettype wire

// ===== rtl/icc_ctrl.sv =====
// Controller state machine sequencing edge insertion and the Kahn peel.
`default_nettype none
module icc_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             s_tvalid,
	output logic                  s_tready,
	output logic                  m_tvalid,
	input  wire logic             m_tready,
	input  wire icc_pkg::icc_sts_t sts,
	output icc_pkg::icc_cmd_t     cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_WR_EDGE,
		ST_INIT,
		ST_PICK,
		ST_APPLY,
		ST_FINISH
	} state_t;

	state_t state_q;
	logic   m_tvalid_q;
	logic   out_free;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign out_free = !m_tvalid_q || m_tready;

	// Command decode
	always_comb begin
		cmd            = '0;
		cmd.load       = (state_q == ST_IDLE) && s_tvalid;
		cmd.rd_src     = (state_q == ST_CHECK);
		cmd.wr_edge    = (state_q == ST_WR_EDGE);
		cmd.peel_init  = (state_q == ST_INIT);
		cmd.peel_pick  = (state_q == ST_PICK) && sts.ready_any;
		cmd.peel_apply = (state_q == ST_APPLY);
		cmd.finish     = (state_q == ST_FINISH) && out_free;
	end

	// State and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			// result taken and no new one loaded this cycle
			if (m_tvalid_q && m_tready && !cmd.finish) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					state_q <= sts.in_range ? ST_WR_EDGE : ST_FINISH;
				end
				ST_WR_EDGE: begin
					state_q <= ST_INIT;
				end
				ST_INIT: begin
					state_q <= ST_PICK;
				end
				ST_PICK: begin
					state_q <= sts.ready_any ? ST_APPLY : ST_FINISH;
				end
				ST_APPLY: begin
					state_q <= ST_PICK;
				end
				ST_FINISH: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== rtl/icc_dpath.sv =====
// Datapath: adjacency memory, in-degree lanes, peel sets and result register.
`default_nettype none
module icc_dpath (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic [icc_pkg::NODE_W-1:0]    src_in,
	input  wire logic [icc_pkg::NODE_W-1:0]    dst_in,
	input  wire logic [5:0]                    node_count,
	input  wire icc_pkg::icc_cmd_t             cmd,
	output icc_pkg::icc_sts_t                  sts,
	output logic                               out_accepted,
	output logic                               out_cycle_found,
	output logic [icc_pkg::CNT_W-1:0]          out_ordered_count,
	output logic [icc_pkg::CNT_W-1:0]          out_seen_count,
	output logic [icc_pkg::REL_W-1:0]          out_relation_number
);

	localparam int N = icc_pkg::MAX_NODES;

	// Adjacency memory, one row per source node
	logic [N-1:0] adj_mem [N];
	logic [N-1:0] adj_vld_q;
	logic [N-1:0] rd_data_s1;
	logic         rd_vld_s1;
	logic [icc_pkg::NODE_W-1:0] rd_addr;
	logic         rd_en;
	logic [N-1:0] row_cur;

	// Graph state
	logic [icc_pkg::DEG_W-1:0] deg_q [N];
	logic [N-1:0]              seen_q;
	logic [icc_pkg::CNT_W-1:0] seen_cnt_q;
	logic [icc_pkg::REL_W-1:0] rel_cnt_q;
	logic                      flag_q;

	// Item and peel working state
	logic [icc_pkg::NODE_W-1:0] src_q;
	logic [icc_pkg::NODE_W-1:0] dst_q;
	logic [icc_pkg::DEG_W-1:0]  tmp_q [N];
	logic [N-1:0]               ready_q;
	logic [N-1:0]               removed_q;
	logic [icc_pkg::CNT_W-1:0]  ordered_q;

	logic [N-1:0]               pick_oh;
	logic [icc_pkg::NODE_W-1:0] pick_idx;
	logic                       src_ok;
	logic                       dst_ok;
	logic                       new_src;
	logic                       new_dst;
	logic                       flag_next;

	// Range check against min(node_count, MAX_NODES)
	assign src_ok = (node_count >= 6'(N)) || (6'(src_q) < node_count);
	assign dst_ok = (node_count >= 6'(N)) || (6'(dst_q) < node_count);

	assign sts.in_range   = src_ok && dst_ok;
	assign sts.ready_any  = |ready_q;
	assign sts.cycle_flag = flag_q;

	// Lowest ready node, isolated and encoded
	assign pick_oh = ready_q & (~ready_q + N'(1));
	always_comb begin
		pick_idx = '0;
		for (int i = 0; i < N; i++) begin
			if (pick_oh[i]) begin
				pick_idx = pick_idx | icc_pkg::NODE_W'(i);
			end
		end
	end

	assign rd_en   = cmd.rd_src || cmd.peel_pick;
	assign rd_addr = cmd.peel_pick ? pick_idx : src_q;
	assign row_cur = rd_vld_s1 ? rd_data_s1 : '0;

	assign new_src   = !seen_q[src_q];
	assign new_dst   = !seen_q[dst_q] && (dst_q != src_q);
	assign flag_next = flag_q || (sts.in_range && (ordered_q != seen_cnt_q));

	// Memory write and registered read
	always_ff @(posedge clk) begin
		if (cmd.wr_edge) begin
			adj_mem[src_q] <= row_cur | (N'(1) << dst_q);
		end
		if (rd_en) begin
			rd_data_s1 <= adj_mem[rd_addr];
		end
	end

	// Graph state, counters and read-valid tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			adj_vld_q  <= '0;
			rd_vld_s1  <= 1'b0;
			seen_q     <= '0;
			seen_cnt_q <= '0;
			rel_cnt_q  <= '0;
			flag_q     <= 1'b0;
			for (int i = 0; i < N; i++) begin
				deg_q[i] <= '0;
			end
		end else begin
			if (rd_en) begin
				rd_vld_s1 <= adj_vld_q[rd_addr];
			end
			if (cmd.load && (rel_cnt_q != icc_pkg::REL_MAX)) begin
				rel_cnt_q <= rel_cnt_q + 1'b1;
			end
			if (cmd.wr_edge) begin
				adj_vld_q[src_q] <= 1'b1;
				seen_q[src_q]    <= 1'b1;
				seen_q[dst_q]    <= 1'b1;
				seen_cnt_q <= seen_cnt_q + icc_pkg::CNT_W'(new_src)
					+ icc_pkg::CNT_W'(new_dst);
				if (!row_cur[dst_q] && (deg_q[dst_q] != icc_pkg::DEG_MAX)) begin
					deg_q[dst_q] <= deg_q[dst_q] + 1'b1;
				end
			end
			if (cmd.finish) begin
				flag_q <= flag_next;
			end
		end
	end

	// Item capture, peel lanes and result register
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			src_q     <= src_in;
			dst_q     <= dst_in;
			ordered_q <= '0;
		end
		if (cmd.peel_init) begin
			removed_q <= '0;
			for (int i = 0; i < N; i++) begin
				tmp_q[i]   <= deg_q[i];
				ready_q[i] <= seen_q[i] && (deg_q[i] == '0);
			end
		end
		if (cmd.peel_pick) begin
			ready_q   <= ready_q & ~pick_oh;
			removed_q <= removed_q | pick_oh;
			ordered_q <= ordered_q + 1'b1;
		end
		if (cmd.peel_apply) begin
			for (int i = 0; i < N; i++) begin
				if (row_cur[i] && (tmp_q[i] != '0)) begin
					tmp_q[i] <= tmp_q[i] - 1'b1;
					if ((tmp_q[i] == icc_pkg::DEG_W'(1)) && seen_q[i] && !removed_q[i]) begin
						ready_q[i] <= 1'b1;
					end
				end
			end
		end
		if (cmd.finish) begin
			out_accepted        <= sts.in_range;
			out_cycle_found     <= flag_next;
			out_ordered_count   <= ordered_q;
			out_seen_count      <= seen_cnt_q;
			out_relation_number <= rel_cnt_q;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/incremental_cycle_check.sv =====
// Top level of the incremental cycle check: config register, controller, datapath.
//
// Input stream (s_tvalid/s_tready/s_tdata) carries one precedence relation
// per item: src_node must come before dst_node. Each item produces exactly
// one result on the output stream (m_tvalid/m_tready/m_tdata): accepted,
// sticky cycle_found, ordered_count, seen_count and relation_number.
// The APB port holds node_count at address 0; write it only while idle.
// A rejected item passes through IDLE, CHECK and FINISH; an accepted one
// through IDLE, CHECK, WR_EDGE, INIT, a PICK and APPLY pair per node the
// peel removes (at most 32), a last PICK and FINISH. Each removed node needs
// a read of its adjacency row from the single-port row memory before its
// successors are decremented. s_tready is high only while the controller
// is idle. A stalled receiver holds the finished result in the output
// register; the block takes the next item meanwhile and waits before
// loading its result. Reset clears the graph, counters and flag at once
// and sets node_count to 26; the row memory is tracked by valid bits.
`default_nettype none
`include "incremental_cycle_check_macros.svh"
module incremental_cycle_check (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	// APB configuration
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [icc_pkg::PADDR_W-1:0]  paddr,
	input  wire logic [31:0]                  pwdata,
	output logic      [31:0]                  prdata,
	output logic                              pready,
	// Relation input
	input  wire logic                         s_tvalid,
	output logic                              s_tready,
	input  wire logic [15:0]                  s_tdata,  // src_node[4:0], dst_node[9:5], zero
	// Result output
	output logic                              m_tvalid,
	input  wire logic                         m_tready,
	// accepted[0], cycle_found[1], ordered_count[7:2], seen_count[13:8],
	// relation_number[29:14], zero[31:30]
	output logic [31:0]                       m_tdata
);

	logic [5:0]               node_count_q;
	logic                     cfg_wr;
	icc_pkg::icc_cmd_t        cmd;
	icc_pkg::icc_sts_t        sts;
	logic                     out_accepted;
	logic                     out_cycle_found;
	logic [icc_pkg::CNT_W-1:0] out_ordered_count;
	logic [icc_pkg::CNT_W-1:0] out_seen_count;
	logic [icc_pkg::REL_W-1:0] out_relation_number;

	// Configuration register
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready
		&& (paddr[2] == icc_pkg::REG_NODE_COUNT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= icc_pkg::NODE_COUNT_RESET;
		end else if (cfg_wr) begin
			node_count_q <= pwdata[5:0];
		end
	end

	assign prdata = (paddr[2] == icc_pkg::REG_NODE_COUNT) ? {26'd0, node_count_q} : 32'd0;

	icc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	icc_dpath u_dpath (
		.clk                 (clk),
		.arst_n              (arst_n),
		.src_in              (s_tdata[4:0]),
		.dst_in              (s_tdata[9:5]),
		.node_count          (node_count_q),
		.cmd                 (cmd),
		.sts                 (sts),
		.out_accepted        (out_accepted),
		.out_cycle_found     (out_cycle_found),
		.out_ordered_count   (out_ordered_count),
		.out_seen_count      (out_seen_count),
		.out_relation_number (out_relation_number)
	);

	assign m_tdata = {2'b00, out_relation_number, out_seen_count, out_ordered_count,
		out_cycle_found, out_accepted};

	// A rejected relation never reports removed nodes
	`ICC_ASSERT_IMPLY(a_reject_zero, clk, arst_n, m_tvalid && !m_tdata[0], m_tdata[7:2] == 6'd0)
	// The peel never removes more nodes than have been seen
	`ICC_ASSERT_IMPLY(a_ordered_le_seen, clk, arst_n, m_tvalid, m_tdata[7:2] <= m_tdata[13:8])
	// The inconsistency flag is sticky
	`ICC_ASSERT_NEXT(a_flag_sticky, clk, arst_n, sts.cycle_flag, sts.cycle_flag)
	// Peel commands are never issued while an item can be taken
	`ICC_ASSERT_IMPLY(a_idle_no_peel, clk, arst_n, s_tready, !cmd.peel_pick && !cmd.peel_apply)

endmodule
`default_nettype wire

// ===== dv/icc_relation_checker.sv =====
// Checker for the incremental cycle check: relation predictor and result comparison.
module icc_relation_checker
	import icc_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [31:0]        pwdata,
	input  wire logic [31:0]        prdata,
	input  wire logic               pready,
	input  wire logic               s_tvalid,
	input  wire logic               s_tready,
	input  wire logic [15:0]        s_tdata,  // src_node[4:0], dst_node[9:5], zero
	input  wire logic               m_tvalid,
	input  wire logic               m_tready,
	// accepted[0], cycle_found[1], ordered_count[7:2], seen_count[13:8],
	// relation_number[29:14], zero[31:30]
	input  wire logic [31:0]        m_tdata,
	output int                      mismatches,
	output int                      pending,
	output int                      applied_total,
	output int                      checked_total,
	output bit                      cycle_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [PADDR_W-1:0] NODE_COUNT_ADDR = PADDR_W'(4 * REG_NODE_COUNT);

	typedef struct {
		logic        accepted;
		logic        cycle_found;
		logic [5:0]  ordered_count;
		logic [5:0]  seen_count;
		logic [15:0] relation_number;
	} report_t;

	// Shadow of the graph and the configuration
	logic [31:0]      succ_rows [MAX_NODES];
	logic [DEG_W-1:0] indegree [MAX_NODES];
	logic [31:0]      named_nodes;
	logic [REL_W-1:0] relations_seen;
	logic             cycle_latched;
	logic [5:0]       node_count_reg;

	report_t report_q [$];
	report_t want;

	// Kahn peel over the named nodes; returns how many could be removed
	function automatic logic [5:0] peel_removed();
		logic [DEG_W-1:0] left [MAX_NODES];
		logic [31:0]      ready;
		logic [31:0]      removed;
		logic [31:0]      row;
		logic [5:0]       removed_n;
		int               x;
		ready = '0;
		removed = '0;
		removed_n = '0;
		for (int i = 0; i < MAX_NODES; i++) begin
			left[i] = indegree[i];
			if (named_nodes[i] && left[i] == '0)
				ready[i] = 1'b1;
		end
		while (ready != '0) begin
			// lowest ready node first
			x = 0;
			for (int i = MAX_NODES - 1; i >= 0; i--)
				if (ready[i])
					x = i;
			ready[x] = 1'b0;
			removed[x] = 1'b1;
			removed_n++;
			row = succ_rows[x];
			for (int d = 0; d < MAX_NODES; d++) begin
				if (row[d] && left[d] != '0) begin
					left[d]--;
					if (left[d] == '0 && named_nodes[d] && !removed[d])
						ready[d] = 1'b1;
				end
			end
		end
		return removed_n;
	endfunction

	// Apply one relation to the shadow graph and build the expected result
	function automatic report_t apply_relation(input logic [4:0] src, input logic [4:0] dst);
		report_t    r;
		logic [5:0] limit;
		limit = (node_count_reg > 6'(MAX_NODES)) ? 6'(MAX_NODES) : node_count_reg;
		if (relations_seen != REL_MAX)
			relations_seen++;
		r.accepted = 1'b0;
		r.ordered_count = '0;
		if ({1'b0, src} < limit && {1'b0, dst} < limit) begin
			r.accepted = 1'b1;
			named_nodes[src] = 1'b1;
			named_nodes[dst] = 1'b1;
			// duplicates leave the graph alone
			if (!succ_rows[src][dst]) begin
				succ_rows[src][dst] = 1'b1;
				if (indegree[dst] != DEG_MAX)
					indegree[dst]++;
			end
			r.ordered_count = peel_removed();
			if (r.ordered_count != 6'($countones(named_nodes)))
				cycle_latched = 1'b1;
		end
		r.cycle_found = cycle_latched;
		r.seen_count = 6'($countones(named_nodes));
		r.relation_number = relations_seen;
		return r;
	endfunction

	task automatic check_field(input string what, input int unsigned exp_v,
			input int unsigned act_v);
		if (exp_v != act_v) begin
			mismatches++;
			if (mismatches <= 10)
				$display("icc_relation_checker: %0t %s expected 0x%0h got 0x%0h",
					$realtime, what, exp_v, act_v);
		end
	endtask

	// Watch the three ports, predict on input items, compare on result items
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_NODES; i++) begin
				succ_rows[i] = '0;
				indegree[i] = '0;
			end
			named_nodes = '0;
			relations_seen = '0;
			cycle_latched = 1'b0;
			node_count_reg = NODE_COUNT_RESET;
			report_q.delete();
		end else begin
			if (psel && penable && pready && paddr == NODE_COUNT_ADDR) begin
				if (pwrite)
					node_count_reg = pwdata[5:0];
				else
					check_field("prdata node_count", {26'b0, node_count_reg}, prdata);
			end
			if (m_tvalid && m_tready) begin
				if (report_q.size() == 0) begin
					check_field("result item with none pending", 32'hffff_ffff, m_tdata);
				end else begin
					want = report_q.pop_front();
					check_field("accepted", want.accepted, m_tdata[0]);
					check_field("cycle_found", want.cycle_found, m_tdata[1]);
					check_field("ordered_count", want.ordered_count, m_tdata[7:2]);
					check_field("seen_count", want.seen_count, m_tdata[13:8]);
					check_field("relation_number", want.relation_number, m_tdata[29:14]);
					checked_total++;
				end
			end
			if (s_tvalid && s_tready) begin
				want = apply_relation(s_tdata[4:0], s_tdata[9:5]);
				if (want.accepted)
					applied_total++;
				report_q.insert(report_q.size(), want);
			end
		end
		pending = report_q.size();
		cycle_seen = cycle_latched;
	end

endmodule

// ===== dv/incremental_cycle_check_tb.sv =====
// Testbench top for the incremental cycle check: stimulus, idling, watchdog and verdict.
module incremental_cycle_check_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import icc_pkg::*;

	localparam logic [PADDR_W-1:0] NODE_COUNT_ADDR = PADDR_W'(4 * REG_NODE_COUNT);
	localparam int IDLE_LIMIT = 1000;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [31:0]        pwdata = '0;
	logic [31:0]        prdata;
	logic               pready;
	logic               s_tvalid = 1'b0;
	logic               s_tready;
	logic [15:0]        s_tdata = '0;  // src_node[4:0], dst_node[9:5], zero
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	// accepted[0], cycle_found[1], ordered_count[7:2], seen_count[13:8],
	// relation_number[29:14], zero[31:30]
	logic [31:0]        m_tdata;

	int mismatches;
	int pending;
	int applied_total;
	int checked_total;
	bit cycle_seen;

	int items_sent = 0;
	int idle_run = 0;
	bit send_calm = 1'b0;
	bit recv_calm = 1'b0;
	logic [4:0] last_src = '0;
	logic [4:0] last_dst = '0;

	incremental_cycle_check u_top (.*);

	icc_relation_checker u_check (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// One APB transfer to node_count: setup cycle, then access cycle
	task automatic apb_access(input logic write, input logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= write;
		paddr <= NODE_COUNT_ADDR;
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	// Drain all results, then hold off before touching config
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_node_count(input logic [5:0] value);
		wait_idle();
		apb_access(1'b1, {26'($urandom), value});
		apb_access(1'b0, $urandom);
	endtask

	// Send one relation item, with a random gap ahead of it
	task automatic send_relation(input logic [4:0] src, input logic [4:0] dst);
		int gap;
		gap = send_calm ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			s_tdata <= 16'($urandom);
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {6'b0, dst, src};
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		items_sent++;
		last_src = src;
		last_dst = dst;
		if ($urandom_range(0, 39) == 0)
			send_calm = !send_calm;
	endtask

	// Edge that respects index order, so the graph stays acyclic
	task automatic send_forward(input int top);
		int a;
		a = $urandom_range(0, top - 1);
		send_relation(5'(a), 5'($urandom_range(a + 1, top)));
	endtask

	task automatic send_any(input int top);
		send_relation(5'($urandom_range(0, top)), 5'($urandom_range(0, top)));
	endtask

	// Result side: random stall per item, sometimes only once the result is up
	initial begin
		int gap;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			gap = recv_calm ? 0 : $urandom_range(0, 8);
			if (gap > 0) begin
				m_tready <= 1'b0;
				if ($urandom_range(0, 1) == 1)
					while (!m_tvalid)
						@(negedge clk);
				repeat (gap) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			@(negedge clk);
			if ($urandom_range(0, 39) == 0)
				recv_calm = !recv_calm;
		end
	end

	// Watchdog: cycles without any handshake
	initial begin
		while (idle_run < IDLE_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
					(psel && penable && pready))
				idle_run = 0;
			else
				idle_run++;
		end
		$display("incremental_cycle_check_tb: watchdog expired, %0d results pending", pending);
		$display("incremental_cycle_check_tb: done, errors");
		$finish;
	end

	// Stimulus
	initial begin
		int r;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// reset value of node_count, then directed relations at 26 nodes
		apb_access(1'b0, $urandom);
		send_relation(5'd0, 5'd1);
		send_relation(5'd0, 5'd1);    // duplicate
		send_relation(5'd0, 5'd25);   // highest in-range index
		send_relation(5'd24, 5'd25);
		send_relation(5'd1, 5'd2);
		send_relation(5'd2, 5'd3);
		send_relation(5'd26, 5'd0);   // source at the limit
		send_relation(5'd0, 5'd26);   // target at the limit
		send_relation(5'd31, 5'd31);
		send_relation(5'd31, 5'd0);

		// full width, acyclic graph grown toward all 32 nodes
		set_node_count(6'd32);
		repeat (450) begin
			if ($urandom_range(0, 9) == 0)
				send_relation(last_src, last_dst);
			else
				send_forward(31);
		end

		// no node in range: everything rejected
		set_node_count(6'd0);
		repeat (12) send_any(31);

		// above the maximum; self relation on a sink, then cycles at random
		set_node_count(6'd63);
		send_relation(5'd31, 5'd31);
		send_relation(5'd30, 5'd31);
		repeat (420) begin
			r = $urandom_range(0, 99);
			if (r < 60)
				send_forward(31);
			else if (r < 85)
				send_any(31);
			else
				send_relation(last_src, last_dst);
		end

		// single node: only the self relation on node 0 gets in
		set_node_count(6'd1);
		send_relation(5'd0, 5'd0);
		repeat (25) begin
			if ($urandom_range(0, 2) == 0)
				send_relation(5'd0, 5'd0);
			else
				send_any(31);
		end

		// mid-size limit with a share of rejects
		set_node_count(6'd17);
		repeat (330) begin
			if ($urandom_range(0, 9) < 7)
				send_any(16);
			else
				send_any(31);
		end

		// full width again for the last few relations
		set_node_count(6'd32);
		repeat (12) send_any(31);

		wait_idle();
		repeat (100) @(posedge clk);

		$display("incremental_cycle_check_tb: %0d relations over seven node_count phases,",
			items_sent);
		$display("incremental_cycle_check_tb: %0d applied, %0d results compared, cycle flag %s",
			applied_total, checked_total, cycle_seen ? "raised" : "never raised");
		if (mismatches == 0)
			$display("incremental_cycle_check_tb: done, clean");
		else
			$display("incremental_cycle_check_tb: done, errors");
		$finish;
	end

endmodule

// ===== incremental_cycle_check.f =====
+incdir+rtl
rtl/icc_pkg.sv
rtl/icc_ctrl.sv
rtl/icc_dpath.sv
rtl/incremental_cycle_check.sv
dv/icc_relation_checker.sv
dv/incremental_cycle_check_tb.sv
